[rtl/core/rsa_mexp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rsa_mexp_pkg;

    // width of every operand, configuration register and result field
    localparam int FIELD_W = 31;

    // bit counter of the serial multiplier
    localparam int CNT_W = $clog2(FIELD_W);

    // configuration register indexes
    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

    // input op codes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

[rtl/core/rsa_modular_exponentiation.sv]
`timescale 1ns / 1ps
`default_nettype none

// Modular exponentiation for RSA: each input item (op, value) returns value raised to the
// public exponent (op 0) or private exponent (op 1) modulo the configured modulus, by
// right-to-left square-and-multiply with at most WORD_BITS exponent bits processed. All
// reductions run on one shared bit-serial modular multiplier that takes one multiplier bit
// per cycle; the input value is first reduced through the same unit. One item is worked
// on at a time. A modulus below two gives a result of 0. The next item is accepted while
// a result still waits at the output.
module rsa_modular_exponentiation #(
    parameter int WORD_BITS = 32
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // input channel
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire                               i_op,
    input  wire [rsa_mexp_pkg::FIELD_W-1:0]   i_value,
    // output channel
    output logic                              o_valid,
    input  wire                               i_ready,
    output logic [rsa_mexp_pkg::FIELD_W-1:0]  o_result,
    // configuration port
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire [3:0]                         paddr,
    input  wire [31:0]                        pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import rsa_mexp_pkg::*;

    localparam int ITER_W = $clog2(WORD_BITS + 1);

    // configuration registers
    logic [FIELD_W-1:0] r_modulus;
    logic [FIELD_W-1:0] r_public_exp;
    logic [FIELD_W-1:0] r_private_exp;

    // sequencer and iteration registers
    t_state             r_state, n_state;
    logic [FIELD_W-1:0] r_acc, n_acc;
    logic [FIELD_W-1:0] r_sq, n_sq;
    logic [FIELD_W-1:0] r_exp, n_exp;
    logic [ITER_W-1:0]  r_iter, n_iter;

    // serial multiplier registers
    logic [FIELD_W-1:0] r_mul_a, n_mul_a;
    logic [FIELD_W-1:0] r_mul_b, n_mul_b;
    logic [FIELD_W-1:0] r_mul_r, n_mul_r;
    logic [CNT_W-1:0]   r_mul_cnt, n_mul_cnt;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [FIELD_W-1:0] r_out_result, n_out_result;

    logic               cfg_write;
    logic               in_accept;
    logic               mod_small;
    logic               slot_free;
    logic               mul_last;
    logic               exp_done;
    logic [FIELD_W+1:0] mul_t;
    logic [FIELD_W+2:0] mul_d1;
    logic [FIELD_W+2:0] mul_d2;
    logic [FIELD_W-1:0] mul_res;

    // configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= FIELD_W'(2);
            r_public_exp  <= FIELD_W'(1);
            r_private_exp <= FIELD_W'(1);
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                REG_MODULUS:     r_modulus     <= pwdata[FIELD_W-1:0];
                REG_PUBLIC_EXP:  r_public_exp  <= pwdata[FIELD_W-1:0];
                REG_PRIVATE_EXP: r_private_exp <= pwdata[FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODULUS:     prdata = {1'b0, r_modulus};
            REG_PUBLIC_EXP:  prdata = {1'b0, r_public_exp};
            REG_PRIVATE_EXP: prdata = {1'b0, r_private_exp};
            default:         prdata = '0;
        endcase
    end

    // handshake status
    assign o_ready   = (r_state == ST_IDLE);
    assign in_accept = i_valid && o_ready;
    assign mod_small = (r_modulus < FIELD_W'(2));
    assign slot_free = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out_result;

    // one multiplier bit: r = (2r + bit*b) mod m, with 2r + bit*b below 3m
    assign mul_t   = {1'b0, r_mul_r, 1'b0}
                   + (r_mul_a[FIELD_W-1] ? {2'b00, r_mul_b} : '0);
    assign mul_d1  = {1'b0, mul_t} - {3'b000, r_modulus};
    assign mul_d2  = {1'b0, mul_t} - {2'b00, r_modulus, 1'b0};
    assign mul_res = !mul_d2[FIELD_W+2] ? mul_d2[FIELD_W-1:0]
                   : !mul_d1[FIELD_W+2] ? mul_d1[FIELD_W-1:0]
                   : mul_t[FIELD_W-1:0];
    assign mul_last = (r_mul_cnt == CNT_W'(FIELD_W - 1));

    // loop ends on an exhausted exponent or the iteration cap
    assign exp_done = (r_exp == '0) || (r_iter == ITER_W'(WORD_BITS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = mod_small ? ST_FINISH : ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (mul_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (exp_done) begin
                    n_state = ST_FINISH;
                end else if (r_exp[0]) begin
                    n_state = ST_MUL_ACC;
                end else begin
                    n_state = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC: begin
                if (mul_last) begin
                    n_state = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ: begin
                if (mul_last) begin
                    n_state = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        n_acc        = r_acc;
        n_sq         = r_sq;
        n_exp        = r_exp;
        n_iter       = r_iter;
        n_mul_a      = r_mul_a;
        n_mul_b      = r_mul_b;
        n_mul_r      = r_mul_r;
        n_mul_cnt    = r_mul_cnt;
        n_out_valid  = r_out_valid;
        n_out_result = r_out_result;

        // result taken downstream
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_acc     = mod_small ? '0 : FIELD_W'(1);
                    n_exp     = (i_op == OP_DECRYPT) ? r_private_exp : r_public_exp;
                    n_iter    = '0;
                    n_mul_a   = i_value;
                    n_mul_b   = FIELD_W'(1);
                    n_mul_r   = '0;
                    n_mul_cnt = '0;
                end
            end
            ST_REDUCE, ST_MUL_ACC, ST_MUL_SQ: begin
                n_mul_r   = mul_res;
                n_mul_a   = {r_mul_a[FIELD_W-2:0], 1'b0};
                n_mul_cnt = r_mul_cnt + CNT_W'(1);
                if (mul_last) begin
                    n_mul_r   = '0;
                    n_mul_cnt = '0;
                    n_mul_a   = r_sq;
                    n_mul_b   = r_sq;
                    if (r_state == ST_REDUCE) begin
                        n_sq = mul_res;
                    end else if (r_state == ST_MUL_ACC) begin
                        n_acc = mul_res;
                    end else begin
                        n_sq   = mul_res;
                        n_exp  = {1'b0, r_exp[FIELD_W-1:1]};
                        n_iter = r_iter + ITER_W'(1);
                    end
                end
            end
            ST_CHECK: begin
                n_mul_r   = '0;
                n_mul_cnt = '0;
                n_mul_a   = r_exp[0] ? r_acc : r_sq;
                n_mul_b   = r_sq;
            end
            ST_FINISH: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_result = r_acc;
                end
            end
            default: ;
        endcase
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_acc       <= FIELD_W'(1);
            r_sq        <= '0;
            r_exp       <= '0;
            r_iter      <= '0;
            r_mul_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_sq        <= n_sq;
            r_exp       <= n_exp;
            r_iter      <= n_iter;
            r_mul_cnt   <= n_mul_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_a      <= n_mul_a;
        r_mul_b      <= n_mul_b;
        r_mul_r      <= n_mul_r;
        r_out_result <= n_out_result;
    end

    // checks
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != ST_IDLE))
        else $error("accepted item did not start work");

    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && slot_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished item not moved to output register");

    a_iter_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= ITER_W'(WORD_BITS))
        else $error("iteration count beyond cap");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_cnt <= CNT_W'(FIELD_W - 1))
        else $error("multiplier bit counter out of range");

endmodule

`default_nettype wire

[tb/sv/tb_rsa_modular_exponentiation.sv]
`timescale 1ns / 1ps

module tb_rsa_modular_exponentiation;
    import rsa_mexp_pkg::*;

    localparam int WORD_BITS    = 32;
    localparam int RANDOM_ITEMS = 266;
    localparam int STALL_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 2100;
    localparam int MAX_REPORTS  = 10;

    // register slot past the last key register, writes there are dropped
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    // one directed row: key settings, the item, and a result where it is obvious
    typedef struct packed {
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] pub_exp;
        logic [FIELD_W-1:0] priv_exp;
        logic               op;
        logic [FIELD_W-1:0] value;
        logic               known;
        logic [FIELD_W-1:0] result;
    } t_vector;

    localparam int N_DIRECTED = 24;

    localparam t_vector DIRECTED [N_DIRECTED] = '{
        // reset keys: modulus 2, both exponents 1
        '{31'd2, 31'd1, 31'd1, OP_ENCRYPT, 31'd0, 1'b1, 31'd0},
        '{31'd2, 31'd1, 31'd1, OP_ENCRYPT, 31'd1, 1'b1, 31'd1},
        '{31'd2, 31'd1, 31'd1, OP_DECRYPT, FIELD_MAX, 1'b1, 31'd1},
        '{31'd2, 31'd1, 31'd1, OP_DECRYPT, FIELD_MAX - 31'd1, 1'b1, 31'd0},
        // zero exponent gives one, even for a value that reduces to zero
        '{FIELD_MAX, 31'd0, 31'd0, OP_ENCRYPT, 31'd12345, 1'b1, 31'd1},
        '{FIELD_MAX, 31'd0, 31'd0, OP_DECRYPT, FIELD_MAX, 1'b1, 31'd1},
        // value at and just under the modulus
        '{FIELD_MAX, 31'd1, 31'd1, OP_ENCRYPT, FIELD_MAX, 1'b1, 31'd0},
        '{FIELD_MAX, 31'd1, 31'd1, OP_DECRYPT, FIELD_MAX - 31'd1, 1'b1, FIELD_MAX - 31'd1},
        '{FIELD_MAX, 31'd2, 31'd3, OP_ENCRYPT, FIELD_MAX - 31'd1, 1'b1, 31'd1},
        '{FIELD_MAX, 31'd2, 31'd3, OP_DECRYPT, FIELD_MAX - 31'd1, 1'b1, FIELD_MAX - 31'd1},
        // widest exponents
        '{FIELD_MAX, FIELD_MAX, FIELD_MAX, OP_ENCRYPT, 31'd0, 1'b1, 31'd0},
        '{FIELD_MAX, FIELD_MAX, FIELD_MAX, OP_ENCRYPT, 31'd1, 1'b1, 31'd1},
        '{FIELD_MAX, FIELD_MAX, FIELD_MAX, OP_DECRYPT, 31'd2, 1'b0, 31'd0},
        '{FIELD_MAX, FIELD_MAX, FIELD_MAX, OP_DECRYPT, FIELD_MAX, 1'b1, 31'd0},
        // modulus below two always yields zero
        '{31'd1, 31'd5, 31'd7, OP_ENCRYPT, 31'd999, 1'b1, 31'd0},
        '{31'd1, 31'd5, 31'd7, OP_DECRYPT, FIELD_MAX, 1'b1, 31'd0},
        '{31'd0, 31'd0, FIELD_MAX, OP_ENCRYPT, 31'd5, 1'b1, 31'd0},
        '{31'd0, 31'd0, FIELD_MAX, OP_DECRYPT, 31'd0, 1'b1, 31'd0},
        // textbook key pair, round trip
        '{31'd3233, 31'd17, 31'd2753, OP_ENCRYPT, 31'd65, 1'b1, 31'd2790},
        '{31'd3233, 31'd17, 31'd2753, OP_DECRYPT, 31'd2790, 1'b1, 31'd65},
        '{31'd3233, 31'd17, 31'd2753, OP_ENCRYPT, 31'd4000, 1'b0, 31'd0},
        // power of two modulus, alternating private exponent bits
        '{31'h4000_0000, 31'h4000_0000, 31'h5555_5555, OP_ENCRYPT, 31'd3, 1'b0, 31'd0},
        '{31'h4000_0000, 31'h4000_0000, 31'h5555_5555, OP_DECRYPT, FIELD_MAX, 1'b0, 31'd0},
        '{31'h4000_0000, 31'h4000_0000, 31'h5555_5555, OP_DECRYPT, 31'h2AAA_AAAB, 1'b0, 31'd0}
    };

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_op    = OP_ENCRYPT;
    logic [FIELD_W-1:0] i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [FIELD_W-1:0] o_result;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [3:0]         paddr   = '0;
    logic [31:0]        pwdata  = '0;
    logic [31:0]        prdata;
    logic               pready;

    // local copy of the key registers, reset values
    logic [FIELD_W-1:0] key_modulus = 31'd2;
    logic [FIELD_W-1:0] key_public  = 31'd1;
    logic [FIELD_W-1:0] key_private = 31'd1;

    // side band that travels with the item on the input channel
    logic               cur_known  = 1'b0;
    logic [FIELD_W-1:0] cur_result = '0;

    logic [FIELD_W-1:0] pending_results [$];

    int  fail_count   = 0;
    int  items_in     = 0;
    int  results_out  = 0;
    int  key_settings = 0;
    int  quiet_cycles = 0;
    bit  stall_on     = 1'b1;

    rsa_modular_exponentiation #(
        .WORD_BITS(WORD_BITS)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_op     (i_op),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // right-to-left square and multiply over the local key copy
    function automatic logic [FIELD_W-1:0] modexp_predict(input logic op,
                                                          input logic [FIELD_W-1:0] value);
        longint unsigned m;
        longint unsigned acc;
        longint unsigned sq;
        longint unsigned ex;
        int              i;
        m = {33'd0, key_modulus};
        if (m < 2) begin
            return '0;
        end
        acc = 1;
        sq  = {33'd0, value} % m;
        ex  = {33'd0, ((op == OP_DECRYPT) ? key_private : key_public)};
        for (i = 0; i < WORD_BITS && ex != 0; i++) begin
            if ((ex & 1) != 0) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
            ex = ex >> 1;
        end
        return acc[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] pick_modulus();
        case ($urandom_range(0, 11))
            0:       return 31'd2;
            1:       return 31'd3;
            2:       return FIELD_MAX;
            3:       return FIELD_W'($urandom_range(0, 1));
            4, 5:    return FIELD_W'($urandom_range(2, 1000));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_exponent();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 31'd1;
            2:       return FIELD_MAX;
            3:       return FIELD_W'($urandom_range(2, 100));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return FIELD_MAX;
            2:       return key_modulus;
            3:       return key_modulus - 31'd1;
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // two-phase register write, top data bit random since it is not stored
    task automatic write_reg(input logic [1:0] idx, input logic [FIELD_W-1:0] data);
        logic top;
        top = 1'($urandom_range(0, 1));
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {top, data};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MODULUS:     key_modulus = data;
            REG_PUBLIC_EXP:  key_public  = data;
            REG_PRIVATE_EXP: key_private = data;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_keys(input logic [FIELD_W-1:0] m, input logic [FIELD_W-1:0] e,
                             input logic [FIELD_W-1:0] d);
        write_reg(REG_UNUSED, FIELD_W'($urandom));
        write_reg(REG_MODULUS, m);
        write_reg(REG_PUBLIC_EXP, e);
        write_reg(REG_PRIVATE_EXP, d);
        key_settings++;
    endtask

    // hold valid until the item is taken
    task automatic send_item(input logic op, input logic [FIELD_W-1:0] value,
                             input logic known, input logic [FIELD_W-1:0] result);
        @(negedge i_clk);
        i_valid    <= 1'b1;
        i_op       <= op;
        i_value    <= value;
        cur_known  <= known;
        cur_result <= result;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // block is idle once every pending result is out
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin : rx_stall
        int ready_left;
        if (!stall_on) begin
            i_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            i_ready <= 1'b0;
            ready_left = $urandom_range(0, 30);
        end else begin
            i_ready <= 1'b1;
            ready_left = $urandom_range(0, 10);
        end
    end

    // accept items, check results, watch for a hang
    always @(posedge i_clk) begin : monitor
        logic               moved;
        logic [FIELD_W-1:0] want;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                pending_results.push_back(cur_known ? cur_result
                                                    : modexp_predict(i_op, i_value));
                items_in++;
                moved = 1'b1;
            end
            if (o_valid && i_ready) begin
                results_out++;
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    if (fail_count < MAX_REPORTS) begin
                        $display("%t: unexpected result %h", $realtime, o_result);
                    end
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result !== want) begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("%t: result mismatch, expected %h got %h",
                                     $realtime, want, o_result);
                        end
                        fail_count++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("rsa_modular_exponentiation test failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_vector row;
        int      rand_items;
        int      burst_left;
        int      n;
        rand_items = 0;
        burst_left = 0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, keys reloaded whenever a row asks for new ones
        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED[r];
            if (row.modulus != key_modulus || row.pub_exp != key_public ||
                row.priv_exp != key_private) begin
                drain();
                load_keys(row.modulus, row.pub_exp, row.priv_exp);
            end
            send_item(row.op, row.value, row.known, row.result);
        end

        // random phases, each with fresh keys and its own idling
        while (rand_items < RANDOM_ITEMS) begin
            drain();
            load_keys(pick_modulus(), pick_exponent(), pick_exponent());
            stall_on = ($urandom_range(0, 3) != 0);
            n = $urandom_range(8, 30);
            for (int k = 0; k < n && rand_items < RANDOM_ITEMS; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
                end
                burst_left--;
                send_item(1'($urandom_range(0, 1)), pick_value(), 1'b0, '0);
                rand_items++;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            fail_count += pending_results.size();
        end

        $display("ran %0d items (%0d directed) under %0d key settings",
                 items_in, N_DIRECTED, key_settings);
        $display("checked %0d results, %0d failures", results_out, fail_count);
        if (fail_count == 0) begin
            $display("rsa_modular_exponentiation test passed");
        end else begin
            $display("rsa_modular_exponentiation test failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/rsa_mexp_pkg.sv
rtl/core/rsa_modular_exponentiation.sv
tb/sv/tb_rsa_modular_exponentiation.sv
